### hdl/program_stream_demux_defines.svh
// Assertion macros used by the result queue of the program stream demux RTL.
`ifndef PROGRAM_STREAM_DEMUX_DEFINES_SVH
`define PROGRAM_STREAM_DEMUX_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PSD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psd assertion failed");

// Next-cycle implication, checked out of reset.
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psd assertion failed");

`endif

### hdl/psd_pkg.sv
// Shared types and constants of the program stream demux.
package psd_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_VIDEO_ID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_MSK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AC3_MSK   = 2'd2;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [9:0] stream_code;
      logic       last_in_packet;
      logic       program_end;
   } result_type;

endpackage

### hdl/psd_parse.sv
// Front end: start-code hunt, header parsing and stream selection.
module psd_parse (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [7:0]                     data_byte,
   input  logic                           csr_write_enable,
   input  logic [psd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psd_pkg::CSR_DATA_W-1:0] csr_write_data,
   output logic                           emit,
   output psd_pkg::result_type            result
);

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_ID   = 2'd1;
   localparam logic [1:0] PH_PACK = 2'd2;
   localparam logic [1:0] PH_PES  = 2'd3;

   localparam logic [7:0] ID_PROG_END = 8'hB9;
   localparam logic [7:0] ID_PACK     = 8'hBA;
   localparam logic [7:0] ID_PRIV1    = 8'hBD;
   localparam logic [7:0] ID_PRIV2    = 8'hBF;

   localparam logic [psd_pkg::CSR_IDX_W-1:0] CSR_VIDEO_ID_L  = psd_pkg::CSR_VIDEO_ID;
   localparam logic [psd_pkg::CSR_IDX_W-1:0] CSR_AUDIO_MSK_L = psd_pkg::CSR_AUDIO_MSK;
   localparam logic [psd_pkg::CSR_IDX_W-1:0] CSR_AC3_MSK_L   = psd_pkg::CSR_AC3_MSK;

   logic [7:0]  video_id_ff;
   logic [31:0] audio_mask_ff;
   logic [7:0]  ac3_mask_ff;

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  zero_run_ff, zero_run_in;
   logic [7:0]  start_id_ff, start_id_in;
   logic [16:0] plen_ff, plen_in;
   logic [16:0] bpos_ff, bpos_in;
   logic [7:0]  hdr_len_ff, hdr_len_in;
   logic [8:0]  pstart_ff, pstart_in;
   logic [9:0]  ext_id_ff, ext_id_in;
   logic        sel_ff, sel_in;

   logic        priv;
   logic [17:0] pos_next;
   logic [16:0] pack_len;
   logic [9:0]  sub_code;

   function automatic logic is_selected(input logic [9:0]  code,
                                        input logic [7:0]  vid,
                                        input logic [31:0] amask,
                                        input logic [7:0]  cmask);
      logic hit;
      hit = 1'b0;
      if (code[9:5] == 5'b00110)
         hit = amask[code[4:0]];
      else if (code[9:4] == 6'h0E)
         hit = (code[7:0] == vid);
      else if (code[9:3] == 7'h30)
         hit = cmask[code[2:0]];
      return hit;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         video_id_ff   <= 8'hE0;
         audio_mask_ff <= '1;
         ac3_mask_ff   <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VIDEO_ID_L:  video_id_ff   <= csr_write_data[7:0];
            CSR_AUDIO_MSK_L: audio_mask_ff <= csr_write_data;
            CSR_AC3_MSK_L:   ac3_mask_ff   <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   assign priv     = (start_id_ff == ID_PRIV1) || (start_id_ff == ID_PRIV2);
   assign pos_next = {1'b0, bpos_ff} + 18'd1;
   assign pack_len = 17'd14 + {14'd0, data_byte[2:0]};
   assign sub_code = {((start_id_ff == ID_PRIV1) ? 2'b01 : 2'b10), data_byte};

   always_comb begin
      phase_in    = phase_ff;
      zero_run_in = zero_run_ff;
      start_id_in = start_id_ff;
      plen_in     = plen_ff;
      bpos_in     = bpos_ff;
      hdr_len_in  = hdr_len_ff;
      pstart_in   = pstart_ff;
      ext_id_in   = ext_id_ff;
      sel_in      = sel_ff;
      emit        = 1'b0;
      result      = '0;

      unique case (phase_ff)
         PH_ID: begin
            start_id_in = data_byte;
            sel_in      = 1'b0;
            pstart_in   = '0;
            bpos_in     = 17'd4;
            if (data_byte < ID_PROG_END) begin
               phase_in    = PH_HUNT;
               zero_run_in = (data_byte == 8'd0) ? 2'd1 : 2'd0;
            end else if (data_byte == ID_PROG_END) begin
               emit               = 1'b1;
               result.stream_code = {2'b00, ID_PROG_END};
               result.program_end = 1'b1;
               phase_in           = PH_HUNT;
               zero_run_in        = 2'd0;
            end else if (data_byte == ID_PACK) begin
               plen_in  = 17'd14;
               phase_in = PH_PACK;
            end else begin
               plen_in  = '0;
               phase_in = PH_PES;
            end
         end
         PH_PACK: begin
            if (bpos_ff == 17'd13)
               plen_in = pack_len;
            bpos_in = pos_next[16:0];
            if (pos_next[16:0] >= plen_in) begin
               phase_in    = PH_HUNT;
               zero_run_in = 2'd0;
            end
         end
         PH_PES: begin
            if (bpos_ff == 17'd4) begin
               plen_in = {1'b0, data_byte, 8'd0};
            end else if (bpos_ff == 17'd5) begin
               plen_in = (plen_ff | {9'd0, data_byte}) + 17'd6;
            end else if (bpos_ff == 17'd8) begin
               hdr_len_in = data_byte;
               if (!priv) begin
                  ext_id_in = {2'b00, start_id_ff};
                  pstart_in = {1'b0, data_byte} + 9'd9;
                  sel_in    = is_selected({2'b00, start_id_ff}, video_id_ff,
                                          audio_mask_ff, ac3_mask_ff);
               end
            end else if (priv && bpos_ff == {8'd0, {1'b0, hdr_len_ff} + 9'd9}) begin
               ext_id_in = sub_code;
               if (sub_code[9:8] == 2'b01 && sub_code[7:4] == 4'h8)
                  pstart_in = {1'b0, hdr_len_ff} + 9'd13;
               else
                  pstart_in = {1'b0, hdr_len_ff} + 9'd10;
               sel_in = is_selected(sub_code, video_id_ff, audio_mask_ff, ac3_mask_ff);
            end
            // new selection values never open the payload in the byte that sets them
            if (sel_ff && pstart_ff != '0 && bpos_ff >= {8'd0, pstart_ff}
                && bpos_ff < plen_ff) begin
               emit                  = 1'b1;
               result.payload_byte   = data_byte;
               result.stream_code    = ext_id_ff;
               result.last_in_packet = (pos_next == {1'b0, plen_ff});
            end
            bpos_in = pos_next[16:0];
            if (pos_next >= 18'd6 && pos_next >= {1'b0, plen_in}) begin
               phase_in    = PH_HUNT;
               zero_run_in = 2'd0;
            end
         end
         default: begin
            if (data_byte == 8'd1 && zero_run_ff == 2'd2) begin
               phase_in    = PH_ID;
               zero_run_in = 2'd0;
            end else if (data_byte == 8'd0) begin
               if (zero_run_ff != 2'd2)
                  zero_run_in = zero_run_ff + 2'd1;
            end else begin
               zero_run_in = 2'd0;
            end
         end
      endcase

      if (!accept)
         emit = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         zero_run_ff <= '0;
         start_id_ff <= '0;
         plen_ff     <= '0;
         bpos_ff     <= '0;
         hdr_len_ff  <= '0;
         pstart_ff   <= '0;
         ext_id_ff   <= '0;
         sel_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         zero_run_ff <= zero_run_in;
         start_id_ff <= start_id_in;
         plen_ff     <= plen_in;
         bpos_ff     <= bpos_in;
         hdr_len_ff  <= hdr_len_in;
         pstart_ff   <= pstart_in;
         ext_id_ff   <= ext_id_in;
         sel_ff      <= sel_in;
      end
   end

endmodule

### hdl/psd_queue.sv
// Back end: short result queue that drives the result channel.
`include "program_stream_demux_defines.svh"

module psd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  psd_pkg::result_type push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output psd_pkg::result_type out_data
);

   psd_pkg::result_type             mem_ff [psd_pkg::FIFO_DEPTH];
   logic [psd_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [psd_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [psd_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            pop;

   assign full      = (count_ff == psd_pkg::CNT_W'(psd_pkg::FIFO_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PSD_ASSERT_NOW(a_no_overflow, push, !full)
   `PSD_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `PSD_ASSERT_NEXT(a_count_down, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

### hdl/program_stream_demux.sv
// Top level of the program stream demux: parser front end and result queue.
// A result is written into the result queue when its byte is accepted and is shown on rsp_valid from there.
// Throughput: one byte per cycle; req_stall rises only while the 4-word
// result queue is full, which happens only when rsp_stall holds it back.
// Reset (synchronous) empties the queue, returns the parser to the start-code
// hunt and restores video id 0xE0 and all-ones selection masks.
module program_stream_demux (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_payload_byte,
   output logic [9:0]                     rsp_stream_code,
   output logic                           rsp_last_in_packet,
   output logic                           rsp_program_end,
   input  logic                           csr_write_enable,
   input  logic [psd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psd_pkg::CSR_DATA_W-1:0] csr_write_data
);

   logic                accept;
   logic                emit;
   logic                full;
   psd_pkg::result_type result;
   psd_pkg::result_type head;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   psd_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .emit             (emit),
      .result           (result)
   );

   psd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   assign rsp_payload_byte   = head.payload_byte;
   assign rsp_stream_code    = head.stream_code;
   assign rsp_last_in_packet = head.last_in_packet;
   assign rsp_program_end    = head.program_end;

endmodule
